FILE: hw/rtl/tlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlb_pkg;
   localparam int DefMaxEntries = 16;
   localparam int DefPageBits = 20;
   localparam int DefFrameBits = 20;
   localparam int CmdW = 2;
   localparam int FieldW = 20;
   localparam int CountW = 32;
   localparam logic [31:0] LfsrTaps = 32'h8020_0003;
   localparam logic [31:0] LfsrSeed = 32'h0000_ACE1;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      POL_LRU    = 2'd0,
      POL_FIFO   = 2'd1,
      POL_RANDOM = 2'd2,
      POL_SPARE  = 2'd3
   } policy_type;

   typedef enum logic [0:0] {
      CSR_ENTRIES = 1'b0,
      CSR_POLICY  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOD,
      ST_WRITE,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, run search
      logic mod_start; // load modulo unit
      logic mod_step;  // one subtract step
      logic commit;    // update entries and counters
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic need_mod;  // insert with full table, fifo or random
      logic mod_done;
   } stat_type;
endpackage
`default_nettype wire

FILE: hw/rtl/tlb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tlb_datapath
   import tlb_pkg::*;
#(
   parameter int MAX_ENTRIES = DefMaxEntries,
   parameter int PAGE_BITS   = DefPageBits,
   parameter int FRAME_BITS  = DefFrameBits
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctrl_type            ctrl,
   output stat_type                 stat,
   input  wire logic [CmdW-1:0]     cmd,
   input  wire logic [FieldW-1:0]   page_in,
   input  wire logic [FieldW-1:0]   frame_in,
   input  wire logic [4:0]          entries_cfg,
   input  wire logic [1:0]          policy_cfg,
   output logic                     hit_out,
   output logic [FieldW-1:0]        frame_out,
   output logic [CountW-1:0]        hit_total,
   output logic [CountW-1:0]        miss_total
);
   localparam int IdxW = $clog2(MAX_ENTRIES);
   localparam int CntW = $clog2(MAX_ENTRIES + 1);
   localparam int TreeN = 1 << IdxW;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [PAGE_BITS-1:0]   page_ff [MAX_ENTRIES];
   logic [FRAME_BITS-1:0]  frame_ff [MAX_ENTRIES];
   logic [31:0]            stamp_ff [MAX_ENTRIES];
   logic [31:0] gstamp_ff, hits_ff, misses_ff, lfsr_ff;
   cmd_type     cmd_ff;
   logic [PAGE_BITS-1:0]  rpage_ff;
   logic [FRAME_BITS-1:0] rframe_ff;
   logic [CntW-1:0]       n_ff;
   // search results
   logic                  hit_ff, free_ff;
   logic [IdxW-1:0]       hit_idx_ff, free_idx_ff, lru_idx_ff, vict_c;
   logic [FRAME_BITS-1:0] hframe_ff;
   logic [31:0]           mod_ff;
   logic                  hit_res_ff;
   logic [FRAME_BITS-1:0] fout_ff;

   logic [CntW-1:0]  n_c;
   logic [PAGE_BITS-1:0] pg_c;
   logic [IdxW-1:0]  hi_c, fi_c;
   logic             hv_c, fv_c;
   logic [IdxW-1:0]  lru_c;
   logic [31:0]      lfsr_nx;
   logic [31:0]      stamp_nx;
   logic [31:0]      t_stamp [TreeN];
   logic [IdxW-1:0]  t_idx [TreeN];
   logic             t_ok [TreeN];

   always_comb begin
      if (entries_cfg == 5'd0) n_c = CntW'(1);
      else if (32'(entries_cfg) > MAX_ENTRIES) n_c = CntW'(MAX_ENTRIES);
      else n_c = CntW'(entries_cfg);
   end
   assign pg_c = PAGE_BITS'(page_in);
   assign stamp_nx = gstamp_ff + 32'd1;

   // parallel match and first free entry (priority from index zero)
   always_comb begin
      hv_c = 1'b0; fv_c = 1'b0; hi_c = '0; fi_c = '0;
      for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
         if (CntW'(k) < n_c) begin
            if (valid_ff[k] && page_ff[k] == pg_c) begin
               hv_c = 1'b1; hi_c = IdxW'(k);
            end
            if (!valid_ff[k]) begin
               fv_c = 1'b1; fi_c = IdxW'(k);
            end
         end
      end
   end

   // lru search: min tree over the entries in use, left side wins ties
   always_comb begin
      for (int k = 0; k < TreeN; k++) begin
         t_idx[k] = IdxW'(k);
         if (k < MAX_ENTRIES) begin
            t_ok[k]    = CntW'(k) < n_c;
            t_stamp[k] = stamp_ff[k];
         end else begin
            t_ok[k]    = 1'b0;
            t_stamp[k] = '0;
         end
      end
      for (int w = TreeN >> 1; w >= 1; w = w >> 1) begin
         for (int j = 0; j < w; j++) begin
            if (!t_ok[2*j] || (t_ok[2*j+1] && t_stamp[2*j+1] < t_stamp[2*j])) begin
               t_ok[j]    = t_ok[2*j+1];
               t_stamp[j] = t_stamp[2*j+1];
               t_idx[j]   = t_idx[2*j+1];
            end else begin
               t_ok[j]    = t_ok[2*j];
               t_stamp[j] = t_stamp[2*j];
               t_idx[j]   = t_idx[2*j];
            end
         end
      end
      lru_c = t_idx[0];
   end

   assign lfsr_nx = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LfsrTaps) : (lfsr_ff >> 1);

   assign stat.need_mod = (cmd_ff == CMD_INSERT) && !free_ff &&
                          (policy_type'(policy_cfg) == POL_FIFO ||
                           policy_type'(policy_cfg) == POL_RANDOM);
   assign stat.mod_done = mod_ff < 32'(n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         gstamp_ff <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         lfsr_ff   <= LfsrSeed;
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            page_ff[k] <= '0; frame_ff[k] <= '0; stamp_ff[k] <= '0;
         end
      end else begin
         if (ctrl.load) begin
            cmd_ff      <= cmd_type'(cmd);
            rpage_ff    <= pg_c;
            rframe_ff   <= FRAME_BITS'(frame_in);
            n_ff        <= n_c;
            hit_ff      <= hv_c;
            hit_idx_ff  <= hi_c;
            hframe_ff   <= frame_ff[hi_c];
            free_ff     <= fv_c;
            free_idx_ff <= fi_c;
            lru_idx_ff  <= lru_c;
         end
         if (ctrl.mod_start) begin
            if (policy_type'(policy_cfg) == POL_RANDOM) begin
               mod_ff  <= lfsr_nx;
               lfsr_ff <= lfsr_nx;
            end else begin
               mod_ff <= gstamp_ff;
            end
         end else if (ctrl.mod_step && !stat.mod_done) begin
            // subtract the largest power-of-two multiple that fits
            for (int s = 31; s >= 0; s--)
               if ((mod_ff >> s) >= 32'(n_ff)) begin
                  mod_ff <= mod_ff - (32'(n_ff) << s);
                  break;
               end
         end
         if (ctrl.commit) begin
            hit_res_ff <= 1'b0;
            fout_ff    <= '0;
            case (cmd_ff)
               CMD_LOOKUP: begin
                  gstamp_ff <= stamp_nx;
                  if (hit_ff) begin
                     stamp_ff[hit_idx_ff] <= stamp_nx;
                     hits_ff    <= hits_ff + 32'd1;
                     hit_res_ff <= 1'b1;
                     fout_ff    <= hframe_ff;
                  end else begin
                     misses_ff <= misses_ff + 32'd1;
                  end
               end
               CMD_INSERT: begin
                  valid_ff[vict_c] <= 1'b1;
                  page_ff[vict_c]  <= rpage_ff;
                  frame_ff[vict_c] <= rframe_ff;
                  stamp_ff[vict_c] <= gstamp_ff;
               end
               CMD_FLUSH: begin
                  valid_ff  <= '0;
                  hits_ff   <= '0;
                  misses_ff <= '0;
                  for (int k = 0; k < MAX_ENTRIES; k++) begin
                     page_ff[k] <= '0; frame_ff[k] <= '0; stamp_ff[k] <= '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (free_ff) vict_c = free_idx_ff;
      else if (stat.need_mod) vict_c = IdxW'(mod_ff);
      else vict_c = lru_idx_ff;
   end

   assign hit_out    = hit_res_ff;
   assign frame_out  = FieldW'(fout_ff);
   assign hit_total  = hits_ff;
   assign miss_total = misses_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/tlb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tlb_ctrl
   import tlb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   output logic          out_valid,
   input  wire logic     out_ready,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_valid) state_in = ST_SEARCH;
         ST_SEARCH: state_in = stat.need_mod ? ST_MOD : ST_WRITE;
         ST_MOD:    if (stat.mod_done) state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_OUT;
         ST_OUT:    if (out_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready       = 1'b0;
      out_valid      = 1'b0;
      ctrl           = '0;
      case (state_ff)
         ST_IDLE: begin
            in_ready  = 1'b1;
            ctrl.load = in_valid;
         end
         ST_SEARCH: ctrl.mod_start = stat.need_mod;
         ST_MOD:    ctrl.mod_step = 1'b1;
         ST_WRITE:  ctrl.commit = 1'b1;
         ST_OUT:    out_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tlb_lookup_insert_replace_top.sv
// a command passes the search, write and out states; rsp_tvalid is raised in out
// an insert into a full table under fifo or random adds a modulo pass after search
// throughput: one command at a time, next req taken the cycle after the rsp transfer
// reset: synchronous active high; clears entries, stamps, counters, lfsr to its seed
// and the configuration to 16 entries in use, lru policy
`timescale 1ns / 1ps
`default_nettype none
module tlb_lookup_insert_replace_top
   import tlb_pkg::*;
#(
   parameter int MAX_ENTRIES = DefMaxEntries,
   parameter int PAGE_BITS   = DefPageBits,
   parameter int FRAME_BITS  = DefFrameBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[1:0], virtual_page[21:2], new_frame[41:22], zero fill
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // hit[0], frame_out[20:1], hit_total[52:21], miss_total[84:53], zero fill
   output logic [87:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   logic [4:0] entries_ff;
   logic [1:0] policy_ff;
   ctrl_type   ctrl;
   stat_type   stat;
   logic                hit;
   logic [FieldW-1:0]   frame_o;
   logic [CountW-1:0]   hit_tot, miss_tot;

   // configuration register writes, always accepted
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= 5'd16;
         policy_ff  <= POL_LRU;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ENTRIES: entries_ff <= csr_data[4:0];
            CSR_POLICY:  policy_ff  <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   tlb_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .stat, .ctrl
   );

   tlb_datapath #(
      .MAX_ENTRIES(MAX_ENTRIES), .PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)
   ) u_dp (
      .clock, .reset, .ctrl, .stat,
      .cmd(req_tdata[1:0]), .page_in(req_tdata[21:2]), .frame_in(req_tdata[41:22]),
      .entries_cfg(entries_ff), .policy_cfg(policy_ff),
      .hit_out(hit), .frame_out(frame_o), .hit_total(hit_tot), .miss_total(miss_tot)
   );

   assign rsp_tdata = {3'b000, miss_tot, hit_tot, frame_o, hit};

`ifndef SYNTHESIS
   // a miss never carries a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[20:1] == '0)
      else $error("frame on miss");
   // no new request while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("overlap");
   // response stays until transferred
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
`endif
endmodule
`default_nettype wire

FILE: verif/tlb_lookup_insert_replace_checker.sv
`timescale 1ns / 1ps
module tlb_lookup_insert_replace_checker
   import tlb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending,
   output int          hit_seen,
   output int          evict_seen
);
   // highest field first, matching the response packing
   typedef struct packed {
      logic [31:0] misses;
      logic [31:0] hits;
      logic [19:0] frame;
      logic        hit;
   } tlb_answer_type;

   logic        ent_valid [16];
   logic [19:0] ent_page [16];
   logic [19:0] ent_frame [16];
   logic [31:0] ent_stamp [16];
   logic [31:0] stamp_now, hits_now, misses_now, lfsr_now;
   logic [4:0]  size_reg;
   policy_type  policy_reg;
   tlb_answer_type answers_due [$];

   function automatic int live_entries();
      if (size_reg == 0) return 1;
      if (size_reg > 16) return 16;
      return int'(size_reg);
   endfunction

   task automatic translate(input logic [47:0] d);
      cmd_type     op;
      logic [19:0] pg, fr;
      tlb_answer_type a;
      int          n, v;
      op = cmd_type'(d[1:0]);
      pg = d[21:2];
      fr = d[41:22];
      n  = live_entries();
      a  = '0;
      if (op == CMD_LOOKUP) begin
         stamp_now++;
         for (int k = 0; k < n; k++) begin
            if (!a.hit && ent_valid[k] && ent_page[k] == pg) begin
               ent_stamp[k] = stamp_now;
               hits_now++;
               a.hit = 1'b1;
               a.frame = ent_frame[k];
            end
         end
         if (!a.hit) misses_now++;
         else hit_seen++;
      end else if (op == CMD_INSERT) begin
         v = -1;
         for (int k = 0; k < n; k++) if (v < 0 && !ent_valid[k]) v = k;
         if (v < 0) begin
            evict_seen++;
            if (policy_reg == POL_FIFO) v = int'(stamp_now % n);
            else if (policy_reg == POL_RANDOM) begin
               lfsr_now = lfsr_now[0] ? ((lfsr_now >> 1) ^ LfsrTaps) : (lfsr_now >> 1);
               v = int'(lfsr_now % n);
            end else begin
               v = 0;
               for (int k = 1; k < n; k++) if (ent_stamp[k] < ent_stamp[v]) v = k;
            end
         end
         ent_valid[v] = 1'b1;
         ent_page[v]  = pg;
         ent_frame[v] = fr;
         ent_stamp[v] = stamp_now;
      end else if (op == CMD_FLUSH) begin
         for (int k = 0; k < 16; k++) begin
            ent_valid[k] = 0; ent_page[k] = 0; ent_frame[k] = 0; ent_stamp[k] = 0;
         end
         hits_now = 0;
         misses_now = 0;
      end
      a.hits = hits_now;
      a.misses = misses_now;
      answers_due.push_back(a);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) begin
            ent_valid[k] = 0; ent_page[k] = 0; ent_frame[k] = 0; ent_stamp[k] = 0;
         end
         stamp_now = 0; hits_now = 0; misses_now = 0; lfsr_now = LfsrSeed;
         size_reg = 16; policy_reg = POL_LRU;
         answers_due.delete();
         fail_count = 0; hit_seen = 0; evict_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENTRIES) size_reg = csr_data[4:0];
            else policy_reg = policy_type'(csr_data[1:0]);
         end
         // response first: its expectation was queued on an earlier transfer
         if (rsp_tvalid && rsp_tready) begin
            tlb_answer_type got, exp;
            got = rsp_tdata[84:0];
            if (answers_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response %h", $time, got);
            end else begin
               exp = answers_due.pop_front();
               if (got.hit != exp.hit)
                  $display("%0t: hit exp %0d got %0d", $time, exp.hit, got.hit);
               if (got.frame != exp.frame)
                  $display("%0t: frame exp %h got %h", $time, exp.frame, got.frame);
               if (got.hits != exp.hits)
                  $display("%0t: hit_total exp %0d got %0d", $time, exp.hits, got.hits);
               if (got.misses != exp.misses)
                  $display("%0t: miss_total exp %0d got %0d", $time, exp.misses,
                           got.misses);
               if (got != exp) fail_count++;
            end
         end
         if (req_tvalid && req_tready) translate(req_tdata);
      end
      pending = answers_due.size();
   end
endmodule

FILE: verif/tlb_lookup_insert_replace_top_tb.sv
`timescale 1ns / 1ps
module tlb_lookup_insert_replace_top_tb;
   import tlb_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   // cmd, virtual_page, new_frame, zero fill
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   // hit, frame_out, hit_total, miss_total, zero fill
   logic [87:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [7:0]  csr_data = '0;
   int          fail_count, pending, hit_seen, evict_seen;
   int          idle_cycles = 0;
   int          sent = 0;
   bit          calm = 0;          // no idling in the closing stretch
   logic [19:0] recent_pages [8];  // small page pool so lookups hit

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   tlb_lookup_insert_replace_top i_dut (.*);

   tlb_lookup_insert_replace_checker i_check (.*);

   // receiver stalls in random bursts
   initial begin
      int burst;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!calm && $urandom_range(0, 1)) begin
            burst = $urandom_range(1, 8);
            rsp_tready <= 0;
            repeat (burst) @(posedge clock);
         end
      end
   end

   // watchdog: a quiet spell longer than any modulo pass or stall means the design is dead
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("FAIL tlb_lookup_insert_replace_top");
            $finish;
         end
      end
   end

   // valid stays high after the transfer until the next command or a drain
   task automatic send_cmd(input cmd_type op, input logic [19:0] pg, input logic [19:0] fr);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, fr, pg, op};
      @(posedge clock iff req_tready);
      sent++;
   endtask

   // valid stays high after the transfer, the caller drops it
   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock iff csr_ready);
   endtask

   // wait for every expected response, then let a modulo pass drain
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock iff pending == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_cmd();
      int          r;
      logic [19:0] pg;
      r = $urandom_range(0, 99);
      pg = ($urandom_range(0, 3) == 0) ? 20'($urandom) : recent_pages[$urandom_range(0, 7)];
      if (r < 50) send_cmd(CMD_LOOKUP, pg, 20'($urandom));
      else if (r < 92) begin
         pg = ($urandom_range(0, 2) == 0) ? 20'($urandom) : pg;
         recent_pages[$urandom_range(0, 7)] = pg;
         send_cmd(CMD_INSERT, pg, 20'($urandom));
      end else if (r < 97) send_cmd(CMD_FLUSH, 20'($urandom), 20'($urandom));
      else send_cmd(CMD_NOP, 20'($urandom), 20'($urandom));
   endtask

   initial begin
      logic [7:0] sizes [6];
      sizes = '{8'd1, 8'd16, 8'd0, 8'd31, 8'd4, 8'd9};
      for (int k = 0; k < 8; k++) recent_pages[k] = 20'($urandom);
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command, eviction under reset config
      send_cmd(CMD_LOOKUP, 20'h00000, 20'h00000);
      send_cmd(CMD_INSERT, 20'h00000, 20'hFFFFF);
      send_cmd(CMD_INSERT, 20'hFFFFF, 20'h00000);
      send_cmd(CMD_LOOKUP, 20'h00000, 20'h12345);
      send_cmd(CMD_LOOKUP, 20'hFFFFF, 20'h12345);
      send_cmd(CMD_NOP, 20'hFFFFF, 20'hFFFFF);
      for (int k = 0; k < 16; k++) send_cmd(CMD_INSERT, 20'(k + 3), 20'(k));
      send_cmd(CMD_LOOKUP, 20'd3, 20'd0);
      send_cmd(CMD_FLUSH, 20'hAAAAA, 20'h55555);
      send_cmd(CMD_LOOKUP, 20'd3, 20'd0);

      // random phases over sizes (zero and oversize included) and all policies
      for (int ph = 0; ph < 24; ph++) begin
         drain();
         write_csr(CSR_ENTRIES, (ph % 5 == 4) ? 8'($urandom) : sizes[ph % 6]);
         write_csr(CSR_POLICY, 8'(ph % 4) | (8'($urandom) & 8'hFC));
         csr_valid <= 0;
         if (ph == 22) calm = 1;
         repeat (80) random_cmd();
      end
      drain();
      $display("covered %0d commands, %0d lookup hits, %0d evictions", sent, hit_seen,
               evict_seen);
      $display("sizes 0..31 and all four policy codes, with random stalls on both sides");
      if (fail_count == 0)
         $display("PASS tlb_lookup_insert_replace_top");
      else
         $display("FAIL tlb_lookup_insert_replace_top");
      $finish;
   end
endmodule

FILE: filelist.f
hw/rtl/tlb_pkg.sv
hw/rtl/tlb_datapath.sv
hw/rtl/tlb_ctrl.sv
hw/rtl/tlb_lookup_insert_replace_top.sv
verif/tlb_lookup_insert_replace_checker.sv
verif/tlb_lookup_insert_replace_top_tb.sv
